### src/quadtree_image_block_decoder_core_macros.svh
// Assertion macros shared by the quadtree decoder RTL.
`ifndef QUADTREE_IMAGE_BLOCK_DECODER_CORE_MACROS_SVH
`define QUADTREE_IMAGE_BLOCK_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define QTD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qtd assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define QTD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qtd assertion failed");
`else
`define QTD_ASSERT_IMP(label, ante, cons)
`define QTD_ASSERT_NXT(label, ante, cons)
`endif
`endif

### src/qtd_pkg.sv
// Shared types and constants of the quadtree decoder.
package qtd_pkg;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned TDATA_W = 64;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd256;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd256;

  // register indexes, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [COLOR_W-1:0] color;
    logic               tree_done;
    logic               depth_error;
  } qtd_result_t;

endpackage

### src/qtd_walker.sv
// Tree walker: level, quadrant path and origin stack, one token per cycle while fire is high.
`include "quadtree_image_block_decoder_core_macros.svh"
module qtd_walker
  import qtd_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = 12,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               is_leaf,
  input  logic [COLOR_W-1:0] leaf_color,
  input  logic [SIZE_W-1:0]  image_width,
  input  logic [SIZE_W-1:0]  image_height,
  output qtd_result_t        res
);

  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned SW = (COORD_BITS > SIZE_W) ? COORD_BITS + 1 : SIZE_W + 1;

  logic [LW-1:0]         level_r, level_nxt;
  logic [COORD_BITS-1:0] cur_row_r, cur_row_nxt;
  logic [COORD_BITS-1:0] cur_col_r, cur_col_nxt;
  logic [1:0]            quad_r    [MAX_DEPTH];
  logic [1:0]            quad_nxt  [MAX_DEPTH];
  logic [COORD_BITS-1:0] row_stk_r [MAX_DEPTH];
  logic [COORD_BITS-1:0] row_stk_nxt [MAX_DEPTH];
  logic [COORD_BITS-1:0] col_stk_r [MAX_DEPTH];
  logic [COORD_BITS-1:0] col_stk_nxt [MAX_DEPTH];

  logic                  at_max;
  logic [LW-1:0]         pop_lvl;
  logic [1:0]            q_cur, q_new;
  logic [COORD_BITS-1:0] prow, pcol, new_row, new_col;
  logic [SIZE_W-1:0]     hw, hh;

  assign at_max = (level_r == LW'(MAX_DEPTH));

  // pop: deepest open level whose quadrant is not yet the last one
  always_comb begin
    pop_lvl = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((LW'(i) < level_r) && (quad_r[i] != 2'd3)) pop_lvl = LW'(i + 1);
    end
  end

  always_comb begin
    q_cur = 2'd0;
    prow  = '0;
    pcol  = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LW'(i + 1) == pop_lvl) q_cur = quad_r[i];
    end
    for (int i = 0; i < MAX_DEPTH - 1; i++) begin
      if (LW'(i + 2) == pop_lvl) begin
        prow = row_stk_r[i];
        pcol = col_stk_r[i];
      end
    end
  end

  assign q_new   = q_cur + 2'd1;
  assign hw      = image_width >> pop_lvl;
  assign hh      = image_height >> pop_lvl;
  assign new_row = COORD_BITS'(SW'(prow) + (q_new[1] ? SW'(hh) : SW'(0)));
  assign new_col = COORD_BITS'(SW'(pcol) + (q_new[0] ? SW'(hw) : SW'(0)));

  always_comb begin
    level_nxt   = level_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    quad_nxt    = quad_r;
    row_stk_nxt = row_stk_r;
    col_stk_nxt = col_stk_r;
    if (fire) begin
      if (!is_leaf) begin
        if (at_max) begin
          level_nxt   = '0;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end else begin
          // descend to top-left child, which keeps the parent's origin
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if (LW'(i) == level_r) begin
              quad_nxt[i]    = 2'd0;
              row_stk_nxt[i] = cur_row_r;
              col_stk_nxt[i] = cur_col_r;
            end
          end
          level_nxt = level_r + LW'(1);
        end
      end else if (pop_lvl == '0) begin
        level_nxt   = '0;
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end else begin
        // advance to the next sibling at the pop level
        for (int i = 0; i < MAX_DEPTH; i++) begin
          if (LW'(i + 1) == pop_lvl) begin
            quad_nxt[i]    = q_new;
            row_stk_nxt[i] = new_row;
            col_stk_nxt[i] = new_col;
          end
        end
        level_nxt   = pop_lvl;
        cur_row_nxt = new_row;
        cur_col_nxt = new_col;
      end
    end
  end

  always_comb begin
    res             = '0;
    res.valid       = is_leaf || at_max;
    res.depth_error = !is_leaf && at_max;
    if (is_leaf) begin
      res.row       = POS_W'(cur_row_r);
      res.col       = POS_W'(cur_col_r);
      res.width     = image_width >> level_r;
      res.height    = image_height >> level_r;
      res.color     = leaf_color;
      res.tree_done = (pop_lvl == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else begin
      level_r   <= level_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quad_r    <= quad_nxt;
    row_stk_r <= row_stk_nxt;
    col_stk_r <= col_stk_nxt;
  end

  `QTD_ASSERT_IMP(a_level_bound, 1'b1, level_r <= LW'(MAX_DEPTH))
  `QTD_ASSERT_IMP(a_done_xor_err, res.valid, !(res.tree_done && res.depth_error))
  `QTD_ASSERT_NXT(a_done_restart, fire && res.valid && (res.tree_done || res.depth_error),
                  level_r == '0)
  `QTD_ASSERT_NXT(a_descend, fire && !is_leaf && !at_max,
                  level_r == $past(level_r) + LW'(1))
  `QTD_ASSERT_IMP(a_err_zero, res.depth_error,
                  res.width == '0 && res.height == '0 && res.color == '0)

endmodule

### src/qtd_out_reg.sv
// Result register of the quadtree decoder with its stream handshake.
module qtd_out_reg
  import qtd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  qtd_result_t        res,
  output logic               slot_free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  logic               valid_r, valid_nxt;
  logic               load;
  qtd_result_t        data_r;

  assign slot_free = !valid_r || out_tready;
  assign load      = fire && res.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= res;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, data_r.color, data_r.height, data_r.width, data_r.col, data_r.row};
  assign out_tlast  = data_r.tree_done;
  assign out_tuser  = data_r.depth_error;

endmodule

### src/quadtree_image_block_decoder_core.sv
// Quadtree decoder top level: token register, config registers, walker, result register.
// A token passes the token register, then the result register; it waits while the result slot is full.
// Throughput: one token per cycle while the result slot is free; the walker's stack pop is a
// priority encode over MAX_DEPTH levels and the next-sibling origin is one add, both combinational.
// Internal nodes below maximum depth produce no result.
// Reset: tree restarts at the root, image size returns to 256 x 256, both channels empty.
module quadtree_image_block_decoder_core
  import qtd_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = 12,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [COLOR_W-1:0] in_tdata,    // [7:0] leaf_color
  input  logic               in_tuser,    // [0] is_leaf
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,   // [11:0] block_row, [23:12] block_col,
                                          // [36:24] block_width, [49:37] block_height,
                                          // [57:50] fill_color, [63:58] zero
  output logic               out_tlast,   // tree_done
  output logic               out_tuser,   // [0] depth_error
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic               in_valid_r, in_valid_nxt;
  logic               in_leaf_r;
  logic [COLOR_W-1:0] in_color_r;
  logic               fire, slot_free, in_xfer;
  logic [SIZE_W-1:0]  width_r, width_nxt;
  logic [SIZE_W-1:0]  height_r, height_nxt;
  logic               cfg_wr;
  qtd_result_t        res;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WIDTH:  width_nxt  = cfg_pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_nxt = cfg_pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {19'd0, height_r} : {19'd0, width_r};

  // token register; fire consumes it when the result slot can take a transfer
  assign fire      = in_valid_r && slot_free;
  assign in_tready = !in_valid_r || fire;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_leaf_r  <= in_tuser;
      in_color_r <= in_tdata;
    end
  end

  qtd_walker #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .is_leaf      (in_leaf_r),
    .leaf_color   (in_color_r),
    .image_width  (width_r),
    .image_height (height_r),
    .res          (res)
  );

  qtd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
